### rtl/core/skyline_filter_hyperplane_dominance_macros.svh
// assertion macros for the skyline filter
`ifndef SKYLINE_FILTER_HYPERPLANE_DOMINANCE_MACROS_SVH
`define SKYLINE_FILTER_HYPERPLANE_DOMINANCE_MACROS_SVH

// condition holds at every clock edge out of reset
`define SKY_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("skyline check failed");

// antecedent implies consequent in the same cycle
`define SKY_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skyline check failed");

`endif

### rtl/core/skyhd_pkg.sv
// package: constants, codes and sequencer states of the skyline filter
package skyhd_pkg;

  localparam int MAX_DIM     = 8;
  localparam int MAX_EXTREME = 32;
  localparam int MAX_SKYLINE = 64;

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int EXT_W   = $clog2(MAX_EXTREME);
  localparam int SKY_W   = $clog2(MAX_SKYLINE);
  localparam int ECNT_W  = EXT_W + 1;
  localparam int SCNT_W  = SKY_W + 1;
  localparam int EA_W    = EXT_W + DIM_W;
  localparam int SA_W    = SKY_W + DIM_W;

  localparam int COORD_W = 18;
  localparam int ID_W    = 16;
  localparam int CFGD_W  = 4;
  localparam int TOL_W   = 16;
  localparam int BM_W    = 2;
  localparam int CAND_W  = 17;
  localparam int BOUND_W = 17;
  localparam int PROD_W  = 2 * COORD_W + 1;
  localparam int ACC_W   = PROD_W + DIM_W;
  localparam int V_W     = COORD_W + 1 + DIM_W + 1;
  localparam int BP_W    = V_W + CFGD_W;

  localparam logic [BOUND_W-1:0] BOUND_ONE = 17'h10000;

  localparam logic [1:0] MODE_EXT  = 2'd0;
  localparam logic [1:0] MODE_CAND = 2'd1;
  localparam logic [1:0] MODE_FIN  = 2'd2;

  localparam logic [1:0] BND_EXACT  = 2'd1;
  localparam logic [1:0] BND_APPROX = 2'd2;

  localparam logic [1:0] REG_DIM   = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_BMODE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXT_WR,
    ST_DOM_NEXT,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_APPEND,
    ST_BND_START,
    ST_BX_RD,
    ST_BX_ACC,
    ST_BA_RD,
    ST_BA_ACC,
    ST_BND_MUL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

### rtl/core/skyline_filter_hyperplane_dominance.sv
// skyline filter top level: sequencer, shared multiply-accumulate unit and stores
// one coordinate item is taken per cycle while in_stall is low; the item that completes a point starts a walk
// extreme write stores the point coordinate by coordinate; a candidate is compared with each member,
// twice over the skyline, using the single shared multiply-accumulate unit
// finish: exact bound over each extreme pair, or approximate bound over each dimension's extent, then
// one output per survivor; synchronous active-low reset, stores hold no reset values
`include "skyline_filter_hyperplane_dominance_macros.svh"

module skyline_filter_hyperplane_dominance
  import skyhd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic [COORD_W-1:0]  in_coord,
  input  logic [ID_W-1:0]     in_point_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_survivor_valid,
  output logic [ID_W-1:0]     out_survivor_id,
  output logic [BOUND_W-1:0]  out_regret_bound,
  output logic                out_bound_updated,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_t state_r, state_nxt;

  logic [CFGD_W-1:0] dim_r;
  logic [TOL_W-1:0]  tol_r;
  logic [BM_W-1:0]   bmode_r;

  logic [ECNT_W-1:0] ext_cnt_r, ext_cnt_nxt;
  logic [SCNT_W-1:0] sky_cnt_r, sky_cnt_nxt;
  logic [CFGD_W-1:0] coord_cnt_r, coord_cnt_nxt;
  logic [CAND_W-1:0] cand_cnt_r, cand_cnt_nxt;
  logic              kind_r, kind_nxt;
  logic              dir_r, dir_nxt;
  logic              upd_r, upd_nxt;
  logic [SCNT_W-1:0] j_r, j_nxt;
  logic [SCNT_W-1:0] kept_r, kept_nxt;
  logic [EXT_W-1:0]  e_r, e_nxt;
  logic [EXT_W-1:0]  i_r, i_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;

  logic [COORD_W-1:0]        pend_r [MAX_DIM];
  logic [ID_W-1:0]           cand_id_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [V_W-1:0]            sum_r, sum_nxt;
  logic [V_W-1:0]            v_r, v_nxt;
  logic signed [COORD_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [BOUND_W-1:0]        bound_r, bound_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_sv_r, out_sv_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_last_r, out_last_nxt;

  logic [COORD_W-1:0] ext_mem [MAX_EXTREME * MAX_DIM];
  logic [COORD_W-1:0] sky_mem [MAX_SKYLINE * MAX_DIM];
  logic [ID_W-1:0]    id_mem  [MAX_SKYLINE];
  logic [COORD_W-1:0] ext_a_r, ext_b_r, sky_rd_r;
  logic [ID_W-1:0]    id_rd_r;

  logic               ext_we, sky_we, id_we;
  logic [COORD_W-1:0] sky_wdata;
  logic [ID_W-1:0]    id_wdata;

  logic                  in_fire, out_fire, cfg_we, can_load;
  logic [DIM_W-1:0]      dlast;
  logic [CFGD_W-1:0]     d_eff;
  logic [CFGD_W-1:0]     ccnt;
  logic                  res_fin, res_dom;
  logic [COORD_W-1:0]    pend_k;
  logic signed [COORD_W:0]  diff;
  logic signed [ACC_W-1:0]  acc_sum, lim;
  logic signed [COORD_W:0]  pdiff;
  logic [COORD_W:0]         pabs;
  logic signed [COORD_W:0]  extent;
  logic signed [COORD_W-1:0] ca, lo_c, hi_c;
  logic [BP_W-1:0]          bprod;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && (in_mode == MODE_FIN));

  assign out_valid          = out_valid_r;
  assign out_survivor_valid = out_sv_r;
  assign out_survivor_id    = out_id_r;
  assign out_regret_bound   = bound_r;
  assign out_bound_updated  = upd_r;
  assign out_last           = out_last_r;

  always_comb begin
    if (dim_r == '0) begin
      d_eff = CFGD_W'(1);
    end else if (dim_r > CFGD_W'(MAX_DIM)) begin
      d_eff = CFGD_W'(MAX_DIM);
    end else begin
      d_eff = dim_r;
    end
  end
  assign dlast = DIM_W'(d_eff - CFGD_W'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= CFGD_W'(4);
      tol_r   <= TOL_W'(1);
      bmode_r <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_DIM:   dim_r   <= pwdata[CFGD_W-1:0];
        REG_TOL:   tol_r   <= pwdata[TOL_W-1:0];
        REG_BMODE: bmode_r <= pwdata[BM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIM:   prdata = 32'(dim_r);
      REG_TOL:   prdata = 32'(tol_r);
      REG_BMODE: prdata = 32'(bmode_r);
      default:   prdata = '0;
    endcase
  end

  // stores
  always_ff @(posedge clk) begin
    if (ext_we) begin
      ext_mem[{ext_cnt_r[EXT_W-1:0], k_r}] <= pend_k;
    end
    ext_a_r <= ext_mem[{e_r, k_r}];
    ext_b_r <= ext_mem[{i_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (sky_we) begin
      sky_mem[{kept_r[SKY_W-1:0], k_r}] <= sky_wdata;
    end
    sky_rd_r <= sky_mem[{j_r[SKY_W-1:0], k_r}];
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[kept_r[SKY_W-1:0]] <= id_wdata;
    end
    id_rd_r <= id_mem[j_r[SKY_W-1:0]];
  end

  // pending point and candidate id
  always_ff @(posedge clk) begin
    if (in_fire && (in_mode == MODE_EXT || in_mode == MODE_CAND)) begin
      pend_r[ccnt[DIM_W-1:0]] <= in_coord;
      cand_id_r <= in_point_id;
    end
  end

  always_comb begin
    if (coord_cnt_r != '0 && kind_r != in_mode[0]) begin
      ccnt = '0;
    end else if (coord_cnt_r >= CFGD_W'(MAX_DIM)) begin
      ccnt = '0;
    end else begin
      ccnt = coord_cnt_r;
    end
  end

  // shared arithmetic
  assign pend_k   = pend_r[k_r];
  assign diff     = dir_r ? ($signed({pend_k[COORD_W-1], pend_k}) -
                             $signed({sky_rd_r[COORD_W-1], sky_rd_r}))
                          : ($signed({sky_rd_r[COORD_W-1], sky_rd_r}) -
                             $signed({pend_k[COORD_W-1], pend_k}));
  assign prod_nxt = diff * $signed(ext_a_r);
  assign acc_sum  = acc_r + $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  assign lim      = -$signed({{(ACC_W-TOL_W){1'b0}}, tol_r});

  assign pdiff  = $signed({ext_b_r[COORD_W-1], ext_b_r}) - $signed({ext_a_r[COORD_W-1], ext_a_r});
  assign pabs   = pdiff[COORD_W] ? (COORD_W+1)'(1) + ~pdiff : pdiff;
  assign ca     = $signed(ext_a_r);
  assign lo_c   = (e_r == '0 || ca < lo_r) ? ca : lo_r;
  assign hi_c   = (e_r == '0 || ca > hi_r) ? ca : hi_r;
  assign extent = $signed({hi_c[COORD_W-1], hi_c}) - $signed({lo_c[COORD_W-1], lo_c});
  assign bprod  = v_r * d_eff;

  always_comb begin
    state_nxt     = state_r;
    ext_cnt_nxt   = ext_cnt_r;
    sky_cnt_nxt   = sky_cnt_r;
    coord_cnt_nxt = coord_cnt_r;
    cand_cnt_nxt  = cand_cnt_r;
    kind_nxt      = kind_r;
    dir_nxt       = dir_r;
    upd_nxt       = upd_r;
    j_nxt         = j_r;
    kept_nxt      = kept_r;
    e_nxt         = e_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    v_nxt         = v_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bound_nxt     = bound_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_sv_nxt    = out_sv_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    ext_we        = 1'b0;
    sky_we        = 1'b0;
    id_we         = 1'b0;
    sky_wdata     = pend_k;
    id_wdata      = cand_id_r;
    res_fin       = 1'b0;
    res_dom       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_EXT, MODE_CAND: begin
              kind_nxt = in_mode[0];
              if (ccnt + CFGD_W'(1) >= d_eff) begin
                coord_cnt_nxt = '0;
                k_nxt         = '0;
                if (in_mode == MODE_EXT) begin
                  if (ext_cnt_r < ECNT_W'(MAX_EXTREME)) begin
                    state_nxt = ST_EXT_WR;
                  end
                end else begin
                  if (cand_cnt_r != '1) begin
                    cand_cnt_nxt = cand_cnt_r + CAND_W'(1);
                  end
                  dir_nxt   = 1'b0;
                  j_nxt     = '0;
                  state_nxt = ST_DOM_NEXT;
                end
              end else begin
                coord_cnt_nxt = ccnt + CFGD_W'(1);
              end
            end
            MODE_FIN: begin
              upd_nxt   = (cand_cnt_r >= CAND_W'(2));
              state_nxt = ST_BND_START;
            end
            default: ;
          endcase
        end
      end

      ST_EXT_WR: begin
        ext_we = 1'b1;
        if (k_r == dlast) begin
          ext_cnt_nxt = ext_cnt_r + ECNT_W'(1);
          state_nxt   = ST_IDLE;
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
      end

      ST_DOM_NEXT: begin
        if (j_r == sky_cnt_r) begin
          if (!dir_r) begin
            dir_nxt  = 1'b1;
            j_nxt    = '0;
            kept_nxt = '0;
          end else if (!kept_r[SKY_W]) begin
            k_nxt     = '0;
            state_nxt = ST_APPEND;
          end else begin
            sky_cnt_nxt = kept_r;
            state_nxt   = ST_IDLE;
          end
        end else if (ext_cnt_r == '0) begin
          res_fin = 1'b1;
          res_dom = 1'b1;
        end else begin
          e_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_MAC_RD;
        end
      end

      ST_MAC_RD: begin
        state_nxt = ST_MAC_MUL;
      end

      ST_MAC_MUL: begin
        state_nxt = ST_MAC_ACC;
      end

      ST_MAC_ACC: begin
        state_nxt = ST_MAC_RD;
        if (k_r == dlast) begin
          k_nxt   = '0;
          acc_nxt = '0;
          if (acc_sum < lim) begin
            res_fin = 1'b1;
          end else if (ECNT_W'(e_r) + ECNT_W'(1) == ext_cnt_r) begin
            res_fin = 1'b1;
            res_dom = 1'b1;
          end else begin
            e_nxt = e_r + EXT_W'(1);
          end
        end else begin
          k_nxt   = k_r + DIM_W'(1);
          acc_nxt = acc_sum;
        end
      end

      ST_COPY_RD: begin
        state_nxt = ST_COPY_WR;
      end

      ST_COPY_WR: begin
        sky_we    = 1'b1;
        sky_wdata = sky_rd_r;
        id_wdata  = id_rd_r;
        if (k_r == dlast) begin
          id_we     = 1'b1;
          kept_nxt  = kept_r + SCNT_W'(1);
          j_nxt     = j_r + SCNT_W'(1);
          state_nxt = ST_DOM_NEXT;
        end else begin
          k_nxt     = k_r + DIM_W'(1);
          state_nxt = ST_COPY_RD;
        end
      end

      ST_APPEND: begin
        sky_we = 1'b1;
        if (k_r == dlast) begin
          id_we       = 1'b1;
          sky_cnt_nxt = kept_r + SCNT_W'(1);
          state_nxt   = ST_IDLE;
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
      end

      ST_BND_START: begin
        j_nxt = '0;
        k_nxt = '0;
        v_nxt = '0;
        if (!upd_r) begin
          bound_nxt = '0;
          state_nxt = ST_EMIT_RD;
        end else if ((bmode_r != BND_EXACT && bmode_r != BND_APPROX) || ext_cnt_r == '0) begin
          bound_nxt = BOUND_ONE;
          state_nxt = ST_EMIT_RD;
        end else if (bmode_r == BND_EXACT) begin
          sum_nxt = '0;
          i_nxt   = '0;
          e_nxt   = EXT_W'(1);
          if (ext_cnt_r < ECNT_W'(2)) begin
            state_nxt = ST_BND_MUL;
          end else begin
            state_nxt = ST_BX_RD;
          end
        end else begin
          e_nxt     = '0;
          state_nxt = ST_BA_RD;
        end
      end

      ST_BX_RD: begin
        state_nxt = ST_BX_ACC;
      end

      ST_BX_ACC: begin
        state_nxt = ST_BX_RD;
        if (k_r == dlast) begin
          k_nxt   = '0;
          sum_nxt = '0;
          if (sum_r + V_W'(pabs) > v_r) begin
            v_nxt = sum_r + V_W'(pabs);
          end
          if (ECNT_W'(e_r) + ECNT_W'(1) == ext_cnt_r) begin
            if (ECNT_W'(i_r) + ECNT_W'(2) == ext_cnt_r) begin
              state_nxt = ST_BND_MUL;
            end else begin
              i_nxt = i_r + EXT_W'(1);
              e_nxt = i_r + EXT_W'(2);
            end
          end else begin
            e_nxt = e_r + EXT_W'(1);
          end
        end else begin
          k_nxt   = k_r + DIM_W'(1);
          sum_nxt = sum_r + V_W'(pabs);
        end
      end

      ST_BA_RD: begin
        state_nxt = ST_BA_ACC;
      end

      ST_BA_ACC: begin
        lo_nxt    = lo_c;
        hi_nxt    = hi_c;
        state_nxt = ST_BA_RD;
        if (ECNT_W'(e_r) + ECNT_W'(1) == ext_cnt_r) begin
          v_nxt = v_r + V_W'($unsigned(extent));
          e_nxt = '0;
          if (k_r == dlast) begin
            state_nxt = ST_BND_MUL;
          end else begin
            k_nxt = k_r + DIM_W'(1);
          end
        end else begin
          e_nxt = e_r + EXT_W'(1);
        end
      end

      ST_BND_MUL: begin
        bound_nxt = (bprod >= BP_W'(BOUND_ONE)) ? BOUND_ONE : bprod[BOUND_W-1:0];
        j_nxt     = '0;
        state_nxt = ST_EMIT_RD;
      end

      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_sv_nxt    = (sky_cnt_r != '0);
          out_id_nxt    = (sky_cnt_r != '0) ? id_rd_r : '0;
          out_last_nxt  = (sky_cnt_r == '0) || (j_r + SCNT_W'(1) == sky_cnt_r);
          if (out_last_nxt) begin
            ext_cnt_nxt   = '0;
            sky_cnt_nxt   = '0;
            coord_cnt_nxt = '0;
            cand_cnt_nxt  = '0;
            kind_nxt      = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            j_nxt     = j_r + SCNT_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // outcome of one member compare
    if (res_fin) begin
      state_nxt = ST_DOM_NEXT;
      if (!dir_r) begin
        if (res_dom) begin
          state_nxt = ST_IDLE;
        end else begin
          j_nxt = j_r + SCNT_W'(1);
        end
      end else if (res_dom) begin
        j_nxt = j_r + SCNT_W'(1);
      end else if (kept_r == j_r) begin
        kept_nxt = kept_r + SCNT_W'(1);
        j_nxt    = j_r + SCNT_W'(1);
      end else begin
        k_nxt     = '0;
        state_nxt = ST_COPY_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ext_cnt_r   <= '0;
      sky_cnt_r   <= '0;
      coord_cnt_r <= '0;
      cand_cnt_r  <= '0;
      kind_r      <= 1'b0;
      dir_r       <= 1'b0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ext_cnt_r   <= ext_cnt_nxt;
      sky_cnt_r   <= sky_cnt_nxt;
      coord_cnt_r <= coord_cnt_nxt;
      cand_cnt_r  <= cand_cnt_nxt;
      kind_r      <= kind_nxt;
      dir_r       <= dir_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    kept_r     <= kept_nxt;
    e_r        <= e_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    v_r        <= v_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    bound_r    <= bound_nxt;
    out_sv_r   <= out_sv_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  `SKY_ASSERT_IMPLY(a_busy_stalls, state_r != ST_IDLE, in_stall)
  `SKY_ASSERT_ALWAYS(a_sky_cnt_range, sky_cnt_r <= SCNT_W'(MAX_SKYLINE))
  `SKY_ASSERT_ALWAYS(a_ext_cnt_range, ext_cnt_r <= ECNT_W'(MAX_EXTREME))
  `SKY_ASSERT_IMPLY(a_kept_behind, dir_r && state_r == ST_COPY_WR, kept_r < j_r)

endmodule
